>>> hdl/sobel_pkg.sv
// ============================================================================
// sobel_pkg : shared types and constants for the Sobel edge core
// Holds the configuration register codes, the job record passed from the
// front end to the back end, and the pixel packing constants.
// ============================================================================
package sobel_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int PIX_W          = 24;
  localparam int ROW_W          = 12;
  localparam int COL_W          = 10;
  localparam int FW_W           = 11;
  localparam int FH_W           = 13;
  localparam int QDEPTH         = 2;

  localparam logic [10:0] FW_RESET = 11'd640;
  localparam logic [12:0] FH_RESET = 13'd480;

  // register byte addresses
  localparam logic [2:0] ADDR_WIDTH_REG  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT_REG = 3'd4;

  // one window job: 4x3 pixel rows (rows 0..3, cols 0..2) and emit flags
  typedef struct packed {
    logic [3:0][2:0][PIX_W-1:0] grid;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic [3:0]                 emit;   // bit = ro*2+co
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SUM,
    BK_ROOT,
    BK_SEND
  } bk_state_t;

endpackage

>>> hdl/sobel_edge_magnitude_rgb_core.sv
// ============================================================================
// sobel_edge_magnitude_rgb_core : 3x3 Sobel edge magnitude, RGB stream
// Top level: APB register port, front end, job queue and back end.
// ============================================================================
// Usage:
//   s_tvalid/s_tready/s_tdata carry raster-order pixels of a frame of
//   frame_width x frame_height. Each pixel completes zero to four output
//   pixels, sent on m_tvalid/m_tready/m_tdata with tlast on the final one
//   of each input. Registers: frame_width at 0x0, frame_height at 0x4.
//   Flow: the front end handles an input in two phases (line store read,
//   then update) and accepts no new input in the second. In the back end
//   each output pixel passes a gradient state, the bit-serial square root
//   (nine result bits) and a send state; each input with outputs adds a
//   pass through the idle state as its job is taken. A two-entry job queue
//   decouples the sides. When the receiver stalls the result holds
//   and the queue fills, then s_tready drops. Reset clears counters, window
//   and registers to 640 x 480; line stores need no clearing since reads
//   are masked by row position.
module sobel_edge_magnitude_rgb_core #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_red, out_green, out_blue, out_row, out_col
  output logic        m_tlast    // last_of_run
);
  import sobel_pkg::*;

  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic        jf_valid, jf_ready, jb_valid, jb_ready;
  job_t        jf, jbk;
  logic [45:0] odata;

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        ADDR_WIDTH_REG:  frame_width  <= pwdata[10:0];
        ADDR_HEIGHT_REG: frame_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr)
      ADDR_WIDTH_REG:  prdata = {21'd0, frame_width};
      ADDR_HEIGHT_REG: prdata = {19'd0, frame_height};
      default:         prdata = '0;
    endcase
  end

  // pixel packing: red high
  sobel_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .frame_width, .frame_height,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_pix({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
    .job_valid(jf_valid), .job_ready(jf_ready), .job(jf)
  );

  sobel_queue u_queue (
    .clk, .rst, .wr_valid(jf_valid), .wr_ready(jf_ready), .wr_data(jf),
    .rd_valid(jb_valid), .rd_ready(jb_ready), .rd_data(jbk)
  );

  sobel_back u_back (
    .clk, .rst, .job_valid(jb_valid), .job_ready(jb_ready), .job(jbk),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(odata), .out_last(m_tlast)
  );

  // odata = {col, row, blue, green, red}
  assign m_tdata = {2'b00, odata};

  // assertions
  a_tlast_only_valid: assert property (@(posedge clk) disable iff (rst)
    m_tlast && !m_tvalid |-> !jb_ready) else $error("queue pop without send");
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    jb_ready |-> m_tvalid && m_tready && m_tlast) else $error("pop off last");
  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    jb_valid && !jb_ready && m_tvalid |=> jb_valid) else $error("queue lost job");

endmodule

>>> hdl/sobel_front.sv
// ============================================================================
// sobel_front : input side of the Sobel core
// Accepts pixels, keeps the line stores and window, and pushes one job per
// pixel into the queue (jobs with nothing to emit are dropped).
// ============================================================================
module sobel_front #(
  parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [10:0]              frame_width,
  input  logic [12:0]              frame_height,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [23:0]              in_pix,
  output logic                     job_valid,
  input  logic                     job_ready,
  output sobel_pkg::job_t          job
);
  import sobel_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] win [6];
  logic [CW-1:0]    col_count;
  logic [RW-1:0]    row_count;

  // two-phase: phase 0 reads the line stores, phase 1 forms the job
  logic             phase;
  logic [PIX_W-1:0] pix_hold, up_rd, mid_rd;
  logic [AW-1:0]    addr;
  logic [CW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;
  logic             col_end, row_last, r1, r2, c1, c2;
  job_t             jb;

  // effective dimensions
  always_comb begin
    if (frame_width == '0) w_eff = CW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(frame_width);
    if (frame_height == '0) h_eff = RW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(frame_height);
  end

  assign col_end  = col_count >= w_eff - CW'(1);
  assign row_last = row_count >= h_eff - RW'(1);
  assign addr     = (32'(col_count) >= MAX_WIDTH) ? AW'(MAX_WIDTH - 1) : col_count[AW-1:0];
  assign r1 = row_count >= RW'(1);
  assign r2 = row_count >= RW'(2);
  assign c1 = col_count >= CW'(1);
  assign c2 = col_count >= CW'(2);

  assign in_ready = !phase;

  // line store reads, registered
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      up_rd    <= upper_mem[addr];
      mid_rd   <= middle_mem[addr];
      pix_hold <= in_pix;
    end
  end

  // job assembly
  always_comb begin
    logic [PIX_W-1:0] cur [3];
    logic             ok [3];
    cur[0] = up_rd; cur[1] = mid_rd; cur[2] = pix_hold;
    ok[0] = r2; ok[1] = r1; ok[2] = 1'b1;
    jb = '0;
    for (int k = 0; k < 3; k++) begin
      jb.grid[k][0] = (ok[k] && c2) ? win[k] : '0;
      jb.grid[k][1] = (ok[k] && c1) ? win[3+k] : '0;
      jb.grid[k][2] = ok[k] ? cur[k] : '0;
    end
    jb.row     = ROW_W'(row_count - RW'(1));
    jb.col     = COL_W'(col_count - CW'(1));
    jb.emit[0] = r1 && c1;
    jb.emit[1] = r1 && col_end;
    jb.emit[2] = row_last && c1;
    jb.emit[3] = row_last && col_end;
  end

  assign job       = jb;
  assign job_valid = phase && (jb.emit != '0);

  // state update when the job transfers (or has nothing to emit)
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      col_count <= '0;
      row_count <= '0;
      for (int k = 0; k < 6; k++) win[k] <= '0;
    end else if (!phase) begin
      if (in_valid) phase <= 1'b1;
    end else if (!job_valid || job_ready) begin
      phase <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        win[k]   <= win[3+k];
        win[3+k] <= jb.grid[k][2];
      end
      if (col_end) begin
        col_count <= '0;
        row_count <= row_last ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // line store writes
  always_ff @(posedge clk) begin
    if (phase && (!job_valid || job_ready)) begin
      upper_mem[addr]  <= mid_rd;
      middle_mem[addr] <= pix_hold;
    end
  end

endmodule

>>> hdl/sobel_queue.sv
// ============================================================================
// sobel_queue : short job queue between front and back ends
// Two-entry register FIFO so each side can stall on its own.
// ============================================================================
module sobel_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  sobel_pkg::job_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output sobel_pkg::job_t rd_data
);
  import sobel_pkg::*;

  job_t       mem [QDEPTH];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

endmodule

>>> hdl/sobel_back.sv
// ============================================================================
// sobel_back : output side of the Sobel core
// For each emitted window: gradient sums, bit-serial square root over the
// three channels, then a registered result toward the output stream.
// ============================================================================
module sobel_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  sobel_pkg::job_t job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [45:0]     out_data,
  output logic            out_last
);
  import sobel_pkg::*;

  bk_state_t    state, state_next;
  logic [1:0]   sel;              // current output slot ro*2+co
  logic [20:0]  ssq [3];          // gx^2+gy^2 per channel
  logic [8:0]   root [3];
  logic [20:0]  rem [3];
  logic [3:0]   bitn;
  logic [7:0]   mag [3];
  logic         is_last;
  logic [2:0]   first_s, next_s;

  // next emitting slot above sel
  function automatic logic [2:0] next_slot(logic [3:0] em, logic [1:0] s);
    logic [2:0] r;
    r = 3'd4;
    for (int i = 3; i >= 0; i--)
      if (em[i] && i > int'(s)) r = 3'(i);
    return r;
  endfunction

  function automatic logic [2:0] first_slot(logic [3:0] em);
    logic [2:0] r;
    r = 3'd4;
    for (int i = 3; i >= 0; i--)
      if (em[i]) r = 3'(i);
    return r;
  endfunction

  // gradients for the selected slot
  logic [20:0] ssq_c [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [11:0] gx, gy;
      logic signed [21:0] sx, sy;
      logic signed [11:0] v [3][3];
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++) begin
          if (sel[0] + b < 3)
            v[a][b] = 12'(job.grid[sel[1] + a][sel[0] + b][16-8*ch +: 8]);
          else
            v[a][b] = '0;
        end
      gx = (v[0][2] - v[0][0]) + 12'sd2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
      gy = (v[2][0] + 12'sd2 * v[2][1] + v[2][2]) - (v[0][0] + 12'sd2 * v[0][1] + v[0][2]);
      sx = 22'(gx);
      sy = 22'(gy);
      ssq_c[ch] = 21'(sx * sx + sy * sy);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    unique case (state)
      BK_IDLE: if (job_valid) state_next = BK_SUM;
      BK_SUM:  state_next = BK_ROOT;
      BK_ROOT: if (bitn == 4'd0) state_next = BK_SEND;
      BK_SEND: if (out_ready) begin
        if (is_last) begin
          job_ready  = 1'b1;
          state_next = BK_IDLE;
        end else begin
          state_next = BK_SUM;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign first_s = first_slot(job.emit);
  assign next_s  = next_slot(job.emit, sel);
  assign is_last = next_s == 3'd4;

  // datapath: restoring square root, one bit per cycle, 9 result bits
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && job_valid) sel <= first_s[1:0];
    if (state == BK_SEND && out_ready && !is_last)
      sel <= next_s[1:0];
    if (state == BK_SUM) begin
      for (int ch = 0; ch < 3; ch++) begin
        ssq[ch]  <= ssq_c[ch];
        rem[ch]  <= ssq_c[ch];
        root[ch] <= '0;
      end
      bitn <= 4'd8;
    end
    if (state == BK_ROOT) begin
      for (int ch = 0; ch < 3; ch++) begin
        logic [20:0] t;
        // trial: (2*root*2^b + 2^(2b))
        t = (21'(root[ch]) << (bitn + 4'd1)) + (21'd1 << (2 * bitn));
        if (rem[ch] >= t) begin
          rem[ch]  <= rem[ch] - t;
          root[ch] <= root[ch] | (9'd1 << bitn);
        end
      end
      if (bitn != 4'd0) bitn <= bitn - 4'd1;
    end
  end

  // rounding and saturation
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [9:0] q;
      q = 10'(root[ch]) + 10'(rem[ch] > 21'(root[ch]));
      if (ssq[ch] > 21'd65280 || q > 10'd255) mag[ch] = 8'd255;
      else mag[ch] = q[7:0];
    end
  end

  assign out_valid = state == BK_SEND;
  assign out_last  = is_last;
  assign out_data  = {COL_W'(job.col + COL_W'(sel[0])),
                      ROW_W'(job.row + ROW_W'(sel[1])),
                      mag[2], mag[1], mag[0]};

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude core testbench
// Streams RGB frames through the core under several frame sizes, predicts
// every output pixel with a behavioral Sobel model and compares them in order.
// ----------------------------------------------------------------------------
module tb;
  import sobel_pkg::*;

  localparam int LINE_DEPTH  = 1024;
  localparam int HEIGHT_MAX  = 4096;
  localparam int DRAIN_WAIT  = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEM_COUNT  = 130;

  typedef logic [2:0][7:0] rgb_t;  // [0] red, [1] green, [2] blue

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } edge_px_t;

  // Behavioral model of the core plus the queue of pending output pixels
  class sobel_scoreboard;
    rgb_t        upper[LINE_DEPTH];
    rgb_t        middle[LINE_DEPTH];
    rgb_t        win[6];
    int unsigned row_cnt, col_cnt, frame_w, frame_h;
    edge_px_t    pending[$];
    int          errors;

    function new();
      foreach (upper[i]) begin
        upper[i] = '0;
        middle[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_cnt = 0;
      col_cnt = 0;
      frame_w = FW_RESET;
      frame_h = FH_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] value);
      if (addr == ADDR_WIDTH_REG) frame_w = value[10:0];
      else if (addr == ADDR_HEIGHT_REG) frame_h = value[12:0];
    endfunction

    // rounded integer square root, saturated
    function int magnitude(int gx, int gy);
      int s, lo;
      s = gx * gx + gy * gy;
      if (s > 255 * 255 + 255) return 255;
      lo = 0;
      while ((lo + 1) * (lo + 1) <= s) lo++;
      if (s > lo * lo + lo) lo++;
      return (lo > 255) ? 255 : lo;
    endfunction

    function void note_pixel(rgb_t px);
      int unsigned w, h, r, c;
      bit col_end, row_last, ok;
      rgb_t grid[4][4];
      rgb_t cur;
      int gx, gy, v, k, ro, co, a, b, ch, n0;
      int mag[3];
      edge_px_t res;
      w = (frame_w == 0) ? 1 : (frame_w > LINE_DEPTH) ? LINE_DEPTH : frame_w;
      h = (frame_h == 0) ? 1 : (frame_h > HEIGHT_MAX) ? HEIGHT_MAX : frame_h;
      r = row_cnt;
      c = col_cnt;
      col_end = c >= w - 1;
      row_last = r >= h - 1;
      if (c >= LINE_DEPTH) c = LINE_DEPTH - 1;
      // window: rows above the frame and columns left of it read as zero
      for (k = 0; k < 4; k++) begin
        for (a = 0; a < 4; a++) grid[k][a] = '0;
      end
      for (k = 0; k < 3; k++) begin
        cur = (k == 0) ? upper[c] : (k == 1) ? middle[c] : px;
        ok = (k == 0) ? (r >= 2) : (k == 1) ? (r >= 1) : 1'b1;
        if (ok && c >= 2) grid[k][0] = win[k];
        if (ok && c >= 1) grid[k][1] = win[3 + k];
        if (ok) grid[k][2] = cur;
      end
      // completed outputs, row first then column
      n0 = pending.size();
      for (ro = 0; ro < 2; ro++) begin
        if (ro == 0 ? (r < 1) : !row_last) continue;
        for (co = 0; co < 2; co++) begin
          if (co == 0 ? (c < 1) : !col_end) continue;
          for (ch = 0; ch < 3; ch++) begin
            gx = 0;
            gy = 0;
            for (a = 0; a < 3; a++) begin
              for (b = 0; b < 3; b++) begin
                v = grid[ro + a][co + b][ch];
                gx += v * (b - 1) * ((a == 1) ? 2 : 1);
                gy += v * (a - 1) * ((b == 1) ? 2 : 1);
              end
            end
            mag[ch] = magnitude(gx, gy);
          end
          res.red = 8'(mag[0]);
          res.green = 8'(mag[1]);
          res.blue = 8'(mag[2]);
          res.row = 12'(r - 1 + ro);
          res.col = 10'(c - 1 + co);
          res.last = 1'b0;
          pending.push_back(res);
        end
      end
      if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
      // shift window and line stores
      for (k = 0; k < 3; k++) begin
        win[k] = win[3 + k];
        win[3 + k] = grid[k][2];
      end
      upper[c] = middle[c];
      middle[c] = px;
      if (col_end) begin
        col_cnt = 0;
        row_cnt = row_last ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check_result(edge_px_t got);
      edge_px_t exp_px;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output pixel row %0d col %0d", got.row, got.col);
        return;
      end
      exp_px = pending.pop_front();
      if (got !== exp_px) begin
        errors++;
        if (errors <= 10)
          $display({"exp r%0d g%0d b%0d row %0d col %0d last %0d, ",
                    "got r%0d g%0d b%0d row %0d col %0d last %0d"},
                   exp_px.red, exp_px.green, exp_px.blue, exp_px.row, exp_px.col,
                   exp_px.last, got.red, got.green, got.blue, got.row, got.col,
                   got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // in_red, in_green, in_blue
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // out_red, out_green, out_blue, out_row, out_col
  logic        m_tlast;        // last_of_run

  sobel_scoreboard sb = new();
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  int pixel_count = 0;

  sobel_edge_magnitude_rgb_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_chan();
    int p;
    p = $urandom_range(0, 7);
    if (p == 0) return 8'd0;
    if (p == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Output side: monitor and watchdog
  always @(posedge clk) begin
    edge_px_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.red = m_tdata[7:0];
      got.green = m_tdata[15:8];
      got.blue = m_tdata[23:16];
      got.row = m_tdata[35:24];
      got.col = m_tdata[45:36];
      got.last = m_tlast;
      sb.check_result(got);
    end
    if (rst || (m_tvalid && m_tready) || (s_tvalid && s_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: random backpressure, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          m_tready = 1'b0;
          repeat (n) @(negedge clk);
        end
        m_tready = 1'b1;
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_pixel(rgb_t px);
    int n;
    n = gap_len();
    @(negedge clk);
    if (n > 0) begin
      s_tvalid = 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = px;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(px);
    pixel_count++;
  endtask

  task automatic send_random(int count);
    rgb_t px;
    repeat (count) begin
      px[0] = rand_chan();
      px[1] = rand_chan();
      px[2] = rand_chan();
      send_pixel(px);
    end
  endtask

  // Stop the sender until every expected pixel is out and the core is idle
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_frame(int w, int h);
    reg_write(ADDR_WIDTH_REG, w);
    reg_write(ADDR_HEIGHT_REG, h);
  endtask

  initial begin
    int w, h, phase;
    rgb_t px;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 3x3 frame with extreme and checkerboard values
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) begin
      px[0] = (i % 2) ? 8'd255 : 8'd0;
      px[1] = (i % 3) ? 8'd0 : 8'd255;
      px[2] = (i == 4) ? 8'd255 : 8'(8'h5A + i);
      send_pixel(px);
    end
    drain();

    // zero width and height act as a single pixel frame
    set_frame(0, 0);
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd0, 8'd0, 8'd0});
    drain();

    // oversized width saturates, then shrink past the column counter
    set_frame(2047, 0);
    send_random(4);
    drain();
    reg_write(ADDR_WIDTH_REG, 1);
    send_random(1);
    drain();

    // oversized height, then shrink below the current row
    set_frame(2, 8191);
    send_random(6);
    drain();
    reg_write(ADDR_HEIGHT_REG, 2);
    send_random(2);
    drain();

    // random frames, full frames only; one 6x5 frame under a long hold-off
    phase = 0;
    while (pixel_count < ITEM_COUNT) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
      h = $urandom_range(1, 5);
      if (phase == 2) begin
        w = 6;
        h = 5;
      end
      set_frame(w, h);
      if (phase == 2) hold_req = 1'b1;
      send_random(w * h);
      drain();
      phase++;
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
